/* sv/mbps_pkg.sv */
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;

  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = 4;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int COUNT_W    = 8;
  localparam int REPORT_OFS_W = 32;
  localparam int OFS_EXT_W  = (OFFSET_BITS > REPORT_OFS_W) ? OFFSET_BITS : REPORT_OFS_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    STATUS_UNIQUE   = 2'd0,
    STATUS_NONE     = 2'd1,
    STATUS_SEVERAL  = 2'd2,
    STATUS_BAD      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_CARE_MASK    = 2'd2,
    REG_PATTERN_LEN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic  active;
    logic  care;
    byte_t pat;
  } cell_ctrl_t;

  typedef struct packed {
    status_t                  status;
    logic [REPORT_OFS_W-1:0]  offset;
    logic [COUNT_W-1:0]       count;
  } report_t;

endpackage

`default_nettype wire

/* sv/masked_byte_pattern_scan.sv */
// Scans a region streamed one byte per request for a pattern of up to 16 bytes
// with per-byte wildcards. A byte is taken every cycle while data_stall is low:
// a row of 16 shift cells holds the newest bytes and each cell compares the byte
// it latches against its pattern byte in the same cycle, so a byte's compare,
// count and offset update are done as it is taken. On a byte with last_byte
// set, one report for the result channel (status, offset of a sole match,
// saturating count) goes into one of two report slots, which let the scan go on
// while a report waits; data_stall rises only when both are full. Registers are
// written through the cfg port, always ready, and take effect from the next byte.
`default_nettype none

module masked_byte_pattern_scan (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                data_valid,
  output logic                                     data_stall,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                last_byte,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic [1:0]                               status,
  output logic [31:0]                              match_offset,
  output logic [7:0]                               match_count
);
  import mbps_pkg::*;

  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [15:0]      care_mask;
  logic [LEN_W-1:0] pattern_length;

  logic       accept;
  logic       bad;
  logic       cells_ok;
  byte_t      pat_bytes [PAT_BYTES];
  byte_t      chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_ok;
  cell_ctrl_t cell_ctrl [MAX_PATTERN];
  report_t    report;
  report_t    main_q;
  report_t    skid_q;
  logic       skid_valid;
  logic       drain;
  logic       push;

  assign cfg_ready  = 1'b1;
  assign data_stall = skid_valid;
  assign accept     = data_valid && !data_stall;
  assign push       = accept && last_byte;
  assign drain      = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_CARE_MASK:    care_mask      <= cfg_data[15:0];
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign bad = (pattern_length == '0) || (pattern_length > LEN_W'(MAX_PATTERN)) ||
               !care_mask[0];

  always_comb begin
    for (int b = 0; b < PAT_BYTES / 2; b++) begin
      pat_bytes[b]                 = pattern_low[8*b +: 8];
      pat_bytes[b + PAT_BYTES / 2] = pattern_high[8*b +: 8];
    end
  end

  assign chain[0] = data_byte;

  // cell k holds the k-th newest byte and matches pattern byte length-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0] idx;
    assign idx = pattern_length - LEN_W'(1) - LEN_W'(k);
    assign cell_ctrl[k].active = (LEN_W'(k) < pattern_length);
    assign cell_ctrl[k].care   = care_mask[idx[PAT_IDX_W-1:0]];
    assign cell_ctrl[k].pat    = pat_bytes[idx[PAT_IDX_W-1:0]];

    mbps_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .clear (last_byte),
      .ctrl  (cell_ctrl[k]),
      .d_in  (chain[k]),
      .d_out (chain[k+1]),
      .ok    (cell_ok[k])
    );
  end

  assign cells_ok = &cell_ok;

  mbps_tally u_tally (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .last     (last_byte),
    .bad      (bad),
    .len      (pattern_length),
    .cells_ok (cells_ok),
    .report   (report)
  );

  // two report slots
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (drain) begin
          main_q     <= skid_q;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!result_valid || drain) begin
          main_q       <= report;
          result_valid <= 1'b1;
        end else begin
          skid_q     <= report;
          skid_valid <= 1'b1;
        end
      end else if (drain) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status       = main_q.status;
  assign match_offset = main_q.offset;
  assign match_count  = main_q.count;

endmodule

`default_nettype wire

/* sv/mbps_cell.sv */
`default_nettype none

module mbps_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                shift,
  input  wire logic                clear,
  input  wire mbps_pkg::cell_ctrl_t ctrl,
  input  wire mbps_pkg::byte_t     d_in,
  output mbps_pkg::byte_t          d_out,
  output logic                     ok
);
  import mbps_pkg::*;

  byte_t held;

  // compare the byte that is about to be latched
  assign ok    = !ctrl.active || !ctrl.care || (d_in == ctrl.pat);
  assign d_out = held;

  always_ff @(posedge clk) begin
    if (rst || (shift && clear)) begin
      held <= '0;
    end else if (shift) begin
      held <= d_in;
    end
  end

endmodule

`default_nettype wire

/* sv/mbps_tally.sv */
`default_nettype none

module mbps_tally (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          last,
  input  wire logic                          bad,
  input  wire logic [mbps_pkg::LEN_W-1:0]    len,
  input  wire logic                          cells_ok,
  output mbps_pkg::report_t                  report
);
  import mbps_pkg::*;

  logic [OFFSET_BITS-1:0] position;
  logic [OFFSET_BITS-1:0] position_next;
  logic [OFFSET_BITS-1:0] latest;
  logic [OFFSET_BITS-1:0] latest_next;
  logic [OFFSET_BITS-1:0] hit_offset;
  logic [OFS_EXT_W-1:0]   offset_ext;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_next;
  logic                   hit;

  always_comb begin
    position_next = (position == '1) ? position : position + OFFSET_BITS'(1);
    hit_offset    = position_next - OFFSET_BITS'(len);
    hit = !bad && cells_ok && (position_next >= OFFSET_BITS'(len));
    count_next  = count;
    latest_next = latest;
    if (hit) begin
      latest_next = hit_offset;
      if (count != COUNT_MAX) begin
        count_next = count + COUNT_W'(1);
      end
    end
    offset_ext = OFS_EXT_W'(latest_next);

    report.offset = '0;
    report.count  = '0;
    if (bad) begin
      report.status = STATUS_BAD;
    end else if (count_next == '0) begin
      report.status = STATUS_NONE;
    end else if (count_next == COUNT_W'(1)) begin
      report.status = STATUS_UNIQUE;
      report.offset = offset_ext[REPORT_OFS_W-1:0];
      report.count  = count_next;
    end else begin
      report.status = STATUS_SEVERAL;
      report.count  = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      position <= '0;
      count    <= '0;
      latest   <= '0;
    end else if (accept) begin
      position <= position_next;
      count    <= count_next;
      latest   <= latest_next;
    end
  end

endmodule

`default_nettype wire

/* sv/mbps_checker.sv */
`default_nettype none

module mbps_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [1:0] status,
  input wire logic [31:0] match_offset,
  input wire logic [7:0] match_count
);
  import mbps_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) &&
      $stable(match_offset) && $stable(match_count))
    else $error("stalled result changed");

  a_unique_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_UNIQUE |-> match_count == 8'd1)
    else $error("unique match without count of one");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_NONE || status == STATUS_BAD) |->
      match_count == 8'd0 && match_offset == 32'd0)
    else $error("no-match or bad report with fields set");

  a_several_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_SEVERAL |->
      match_count > 8'd1 && match_offset == 32'd0)
    else $error("several-match report with bad fields");

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .match_offset (match_offset),
  .match_count  (match_count)
);

`default_nettype wire
